// ===== sv/uyvy_center_region_stats_unit_defines.svh =====
// Assertion macros for the centre-region statistics unit.
// Taken in by the checker files; no other dependencies.
`ifndef UYVY_CENTER_REGION_STATS_UNIT_DEFINES_SVH
`define UYVY_CENTER_REGION_STATS_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define UCRS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define UCRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ucrs_pkg.sv =====
// Shared types and constants for the centre-region statistics unit.
// No dependencies; imported by every RTL module of the block.
package ucrs_pkg;

  // Field and state widths.
  localparam int CFG_W        = 13;
  localparam int CFG_INDEX_W  = 1;
  localparam int LINE_W       = 12;
  localparam int PAIR_W       = 11;
  localparam int PIX_W        = 8;
  localparam int MEAN_W       = 12;
  localparam int MEAN_FRAC    = 4;
  localparam int TOTAL_W      = 28;
  localparam int LUMA_SUM_W   = 28;
  localparam int CHROMA_SUM_W = 27;
  localparam int COUNT_W      = 21;
  localparam int CNT_W        = 16;

  // Default frame size limits.
  localparam int DEFAULT_MAX_WIDTH  = 4096;
  localparam int DEFAULT_MAX_HEIGHT = 4096;

  // Register reset values.
  localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 13'd1920;
  localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 13'd1080;

  // Largest sample count that can still grow by two.
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 21'h1FFFFD;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Request kinds.
  typedef enum logic [1:0] {
    ACT_PIXEL     = 2'd0,
    ACT_END_FRAME = 2'd1,
    ACT_NO_SOURCE = 2'd2
  } action_t;

  // Which frame mean the divider is working on.
  typedef enum logic [1:0] {
    SEL_LUMA = 2'd0,
    SEL_BLUE = 2'd1,
    SEL_RED  = 2'd2
  } mean_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      pixel_en;
    logic      clear_frame;
    logic      no_source_inc;
    logic      div_start;
    mean_sel_t sel;
    logic      capture;
    logic      commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic div_done;
  } status_t;

endpackage

// ===== sv/ucrs_div.sv =====
// Restoring divider giving one clamped 8.4 mean, one quotient bit a cycle.
// Depends on ucrs_pkg.
module ucrs_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [ucrs_pkg::LUMA_SUM_W-1:0]   dividend,
  input  logic [ucrs_pkg::COUNT_W-1:0]      divisor,
  output logic                              done,
  output logic [ucrs_pkg::MEAN_W-1:0]       quotient
);
  import ucrs_pkg::*;

  localparam int HeadShift = MEAN_W - MEAN_FRAC;
  localparam int StepW     = $clog2(MEAN_W);
  localparam logic [StepW-1:0] LastStep = StepW'(MEAN_W - 1);

  logic [LUMA_SUM_W-HeadShift-1:0] head;
  logic [MEAN_W-1:0]               tail;
  logic                            ovf_in;
  logic [COUNT_W-1:0]              rem;
  logic [COUNT_W-1:0]              div_reg;
  logic [MEAN_W-1:0]               low;
  logic [MEAN_W-1:0]               quo;
  logic                            ovf;
  logic                            busy;
  logic [StepW-1:0]                step;
  logic [COUNT_W:0]                trial;
  logic [COUNT_W:0]                diff;
  logic                            fits;

  // The numerator is dividend * 16; its top part is already below the divisor
  // unless the mean would pass its 12-bit range, which is flagged here.
  assign head   = dividend[LUMA_SUM_W-1:HeadShift];
  assign tail   = {dividend[HeadShift-1:0], MEAN_FRAC'(0)};
  assign ovf_in = COUNT_W'(head) >= divisor;

  // One trial subtraction per cycle.
  assign trial = {rem, low[MEAN_W-1]};
  assign diff  = trial - {1'b0, div_reg};
  assign fits  = trial >= {1'b0, div_reg};

  // Sequencing of the iterations.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LastStep) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= ovf_in ? '0 : COUNT_W'(head);
      low     <= tail;
      quo     <= '0;
      ovf     <= ovf_in;
      div_reg <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
      low <= {low[MEAN_W-2:0], 1'b0};
      quo <= {quo[MEAN_W-2:0], fits};
    end
  end

  assign quotient = ovf ? '1 : quo;

endmodule

// ===== sv/ucrs_datapath.sv =====
// Datapath: configuration, window test, frame accumulators, lifetime
// statistics and result registers. Depends on ucrs_pkg and ucrs_div.
module ucrs_datapath #(
  parameter int MAX_WIDTH  = ucrs_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = ucrs_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [ucrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ucrs_pkg::CFG_W-1:0]          cfg_data,
  input  logic [ucrs_pkg::LINE_W-1:0]         line_index,
  input  logic [ucrs_pkg::PAIR_W-1:0]         pair_index,
  input  logic [ucrs_pkg::PIX_W-1:0]          chroma_blue,
  input  logic [ucrs_pkg::PIX_W-1:0]          luma_first,
  input  logic [ucrs_pkg::PIX_W-1:0]          chroma_red,
  input  logic [ucrs_pkg::PIX_W-1:0]          luma_second,
  input  ucrs_pkg::cmd_t                      cmd,
  output ucrs_pkg::status_t                   status,
  output logic [ucrs_pkg::MEAN_W-1:0]         mean_luma,
  output logic [ucrs_pkg::MEAN_W-1:0]         mean_blue_diff,
  output logic [ucrs_pkg::MEAN_W-1:0]         mean_red_diff,
  output logic [ucrs_pkg::TOTAL_W-1:0]        total_mean_luma,
  output logic [ucrs_pkg::TOTAL_W-1:0]        total_mean_blue,
  output logic [ucrs_pkg::TOTAL_W-1:0]        total_mean_red,
  output logic [ucrs_pkg::PIX_W-1:0]          lowest_luma,
  output logic [ucrs_pkg::PIX_W-1:0]          highest_luma,
  output logic [ucrs_pkg::CNT_W-1:0]          frames_counted,
  output logic [ucrs_pkg::CNT_W-1:0]          frames_without_source
);
  import ucrs_pkg::*;

  localparam int DimW     = $clog2(MAX_WIDTH + 1);
  localparam int DimH     = $clog2(MAX_HEIGHT + 1);
  localparam int RowCmpW  = (DimH > LINE_W) ? DimH : LINE_W;
  localparam int ColCmpW  = (DimW > PAIR_W + 1) ? DimW : PAIR_W + 1;
  localparam logic [DimW-1:0] WidthCap  = DimW'(MAX_WIDTH);
  localparam logic [DimH-1:0] HeightCap = DimH'(MAX_HEIGHT);

  logic [CFG_W-1:0]        frame_width;
  logic [CFG_W-1:0]        frame_height;
  logic [DimW-1:0]         width_eff;
  logic [DimH-1:0]         height_eff;
  logic [DimW+1:0]         width_x3;
  logic [DimH+1:0]         height_x3;
  logic                    row_ok;
  logic                    col_ok;
  logic                    sample_en;

  logic [LUMA_SUM_W-1:0]   luma_sum;
  logic [CHROMA_SUM_W-1:0] blue_sum;
  logic [CHROMA_SUM_W-1:0] red_sum;
  logic [COUNT_W-1:0]      luma_sample_count;
  logic [PIX_W-1:0]        frame_low_luma;
  logic [PIX_W-1:0]        frame_high_luma;
  logic [LUMA_SUM_W:0]     luma_add;
  logic [CHROMA_SUM_W:0]   blue_add;
  logic [CHROMA_SUM_W:0]   red_add;
  logic [PIX_W-1:0]        pair_low;
  logic [PIX_W-1:0]        pair_high;

  logic [PIX_W-1:0]        running_low_luma;
  logic [PIX_W-1:0]        running_high_luma;
  logic [PIX_W-1:0]        running_low_next;
  logic [PIX_W-1:0]        running_high_next;
  logic [CNT_W-1:0]        frame_counter;
  logic [CNT_W-1:0]        frame_counter_next;
  logic [CNT_W-1:0]        no_source_counter;
  logic [TOTAL_W-1:0]      luma_total;
  logic [TOTAL_W-1:0]      blue_total;
  logic [TOTAL_W-1:0]      red_total;
  logic [TOTAL_W:0]        luma_total_add;
  logic [TOTAL_W:0]        blue_total_add;
  logic [TOTAL_W:0]        red_total_add;
  logic [TOTAL_W-1:0]      luma_total_next;
  logic [TOTAL_W-1:0]      blue_total_next;
  logic [TOTAL_W-1:0]      red_total_next;

  logic [MEAN_W-1:0]       frame_mean_luma;
  logic [MEAN_W-1:0]       frame_mean_blue;
  logic [MEAN_W-1:0]       frame_mean_red;
  logic [LUMA_SUM_W-1:0]   div_dividend;
  logic [COUNT_W-1:0]      div_divisor;
  logic                    div_done;
  logic [MEAN_W-1:0]       div_quotient;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_FRAME_WIDTH;
      frame_height <= RESET_FRAME_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
      endcase
    end
  end

  // Frame size clamped to the supported maximum, and three times it.
  assign width_eff  = (32'(frame_width) > MAX_WIDTH) ? WidthCap : DimW'(frame_width);
  assign height_eff = (32'(frame_height) > MAX_HEIGHT) ? HeightCap : DimH'(frame_height);
  assign width_x3   = {2'b00, width_eff} + {1'b0, width_eff, 1'b0};
  assign height_x3  = {2'b00, height_eff} + {1'b0, height_eff, 1'b0};

  // Central window test. Rows step by four from h/4; the pixel column of a
  // pair is twice its index plus the odd bit of w/4.
  assign row_ok = (RowCmpW'(line_index) >= RowCmpW'(height_eff[DimH-1:2])) &&
                  (RowCmpW'(line_index) <  RowCmpW'(height_x3[DimH+1:2])) &&
                  (line_index[1:0] == height_eff[3:2]);
  assign col_ok = (ColCmpW'(pair_index) >= ColCmpW'(width_eff[DimW-1:3])) &&
                  (ColCmpW'({pair_index, width_eff[2]}) < ColCmpW'(width_x3[DimW+1:2]));
  assign sample_en = cmd.pixel_en && row_ok && col_ok &&
                     (luma_sample_count <= COUNT_LIMIT);

  // Saturating accumulation and the range of the pair.
  assign luma_add  = {1'b0, luma_sum} +
                     (LUMA_SUM_W + 1)'({1'b0, luma_first} + {1'b0, luma_second});
  assign blue_add  = {1'b0, blue_sum} + (CHROMA_SUM_W + 1)'(chroma_blue);
  assign red_add   = {1'b0, red_sum} + (CHROMA_SUM_W + 1)'(chroma_red);
  assign pair_low  = (luma_first < luma_second) ? luma_first : luma_second;
  assign pair_high = (luma_first > luma_second) ? luma_first : luma_second;

  // Per-frame accumulators.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_frame) begin
      luma_sum          <= '0;
      blue_sum          <= '0;
      red_sum           <= '0;
      luma_sample_count <= '0;
      frame_low_luma    <= '1;
      frame_high_luma   <= '0;
    end else if (sample_en) begin
      luma_sum          <= luma_add[LUMA_SUM_W] ? '1 : luma_add[LUMA_SUM_W-1:0];
      blue_sum          <= blue_add[CHROMA_SUM_W] ? '1 : blue_add[CHROMA_SUM_W-1:0];
      red_sum           <= red_add[CHROMA_SUM_W] ? '1 : red_add[CHROMA_SUM_W-1:0];
      luma_sample_count <= luma_sample_count + COUNT_W'(2);
      if (pair_low < frame_low_luma) begin
        frame_low_luma <= pair_low;
      end
      if (pair_high > frame_high_luma) begin
        frame_high_luma <= pair_high;
      end
    end
  end

  // No-source markers.
  always_ff @(posedge clk) begin
    if (rst) begin
      no_source_counter <= '0;
    end else if (cmd.no_source_inc && (no_source_counter != '1)) begin
      no_source_counter <= no_source_counter + 1'b1;
    end
  end

  // Divider operands: luma over the sample count, chroma over half of it.
  always_comb begin
    case (cmd.sel)
      SEL_BLUE: begin
        div_dividend = {1'b0, blue_sum};
        div_divisor  = {1'b0, luma_sample_count[COUNT_W-1:1]};
      end
      SEL_RED: begin
        div_dividend = {1'b0, red_sum};
        div_divisor  = {1'b0, luma_sample_count[COUNT_W-1:1]};
      end
      default: begin
        div_dividend = luma_sum;
        div_divisor  = luma_sample_count;
      end
    endcase
  end

  ucrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Frame means as they come out of the divider.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      case (cmd.sel)
        SEL_BLUE: frame_mean_blue <= div_quotient;
        SEL_RED:  frame_mean_red  <= div_quotient;
        default:  frame_mean_luma <= div_quotient;
      endcase
    end
  end

  // Lifetime values after this frame is folded in.
  assign luma_total_add     = {1'b0, luma_total} + (TOTAL_W + 1)'(frame_mean_luma);
  assign blue_total_add     = {1'b0, blue_total} + (TOTAL_W + 1)'(frame_mean_blue);
  assign red_total_add      = {1'b0, red_total} + (TOTAL_W + 1)'(frame_mean_red);
  assign luma_total_next    = luma_total_add[TOTAL_W] ? '1 : luma_total_add[TOTAL_W-1:0];
  assign blue_total_next    = blue_total_add[TOTAL_W] ? '1 : blue_total_add[TOTAL_W-1:0];
  assign red_total_next     = red_total_add[TOTAL_W] ? '1 : red_total_add[TOTAL_W-1:0];
  assign running_low_next   = (frame_low_luma < running_low_luma) ?
                              frame_low_luma : running_low_luma;
  assign running_high_next  = (frame_high_luma > running_high_luma) ?
                              frame_high_luma : running_high_luma;
  assign frame_counter_next = (frame_counter == '1) ? frame_counter : frame_counter + 1'b1;

  // Lifetime statistics.
  always_ff @(posedge clk) begin
    if (rst) begin
      luma_total        <= '0;
      blue_total        <= '0;
      red_total         <= '0;
      running_low_luma  <= '1;
      running_high_luma <= '0;
      frame_counter     <= '0;
    end else if (cmd.commit) begin
      luma_total        <= luma_total_next;
      blue_total        <= blue_total_next;
      red_total         <= red_total_next;
      running_low_luma  <= running_low_next;
      running_high_luma <= running_high_next;
      frame_counter     <= frame_counter_next;
    end
  end

  // Result register, loaded when a frame is committed.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mean_luma             <= frame_mean_luma;
      mean_blue_diff        <= frame_mean_blue;
      mean_red_diff         <= frame_mean_red;
      total_mean_luma       <= luma_total_next;
      total_mean_blue       <= blue_total_next;
      total_mean_red        <= red_total_next;
      lowest_luma           <= running_low_next;
      highest_luma          <= running_high_next;
      frames_counted        <= frame_counter_next;
      frames_without_source <= no_source_counter;
    end
  end

  assign status.count_zero = (luma_sample_count == '0);
  assign status.div_done   = div_done;

endmodule

// ===== sv/ucrs_ctrl.sv =====
// Controller: accepts requests, runs the three end-of-frame divisions and
// hands the result to the output register. Depends on ucrs_pkg.
module ucrs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  ucrs_pkg::action_t    action,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  ucrs_pkg::status_t    status,
  output ucrs_pkg::cmd_t       cmd
);
  import ucrs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LAUNCH = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  state_t    state;
  state_t    state_next;
  mean_sel_t sel;
  mean_sel_t sel_next;
  logic      accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    sel_next   = sel;
    cmd        = '0;
    cmd.sel    = sel;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (action)
            ACT_PIXEL: cmd.pixel_en = 1'b1;
            ACT_END_FRAME: begin
              if (status.count_zero) begin
                cmd.clear_frame = 1'b1;
              end else begin
                sel_next   = SEL_LUMA;
                state_next = ST_LAUNCH;
              end
            end
            ACT_NO_SOURCE: begin
              cmd.no_source_inc = 1'b1;
              cmd.clear_frame   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_LAUNCH: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status.div_done) begin
          cmd.capture = 1'b1;
          if (sel == SEL_RED) begin
            state_next = ST_COMMIT;
          end else begin
            sel_next   = (sel == SEL_LUMA) ? SEL_BLUE : SEL_RED;
            state_next = ST_LAUNCH;
          end
        end
      end
      ST_COMMIT: begin
        // The result register must be free or emptied in this cycle.
        if (!out_valid || !out_stall) begin
          cmd.commit      = 1'b1;
          cmd.clear_frame = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State registers and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sel       <= SEL_LUMA;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/uyvy_center_region_stats_unit.sv =====
// Centre-region statistics for a UYVY pixel-pair stream. Pixel pairs, no-source
// markers and end-of-frame markers of frames without samples are taken one per
// cycle while the unit is idle. An end-of-frame marker of a frame with samples
// holds in_stall high while a single shared restoring divider forms the three
// 8.4 means, each by a launch, the quotient bits and a capture, followed by a
// commit; the commit also waits while an earlier result is still stalled at the
// output. The result register lets new requests in while a result waits.
// Depends on ucrs_pkg, ucrs_ctrl and ucrs_datapath.
module uyvy_center_region_stats_unit #(
  parameter int MAX_WIDTH  = ucrs_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = ucrs_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [ucrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ucrs_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          action,
  input  logic [ucrs_pkg::LINE_W-1:0]         line_index,
  input  logic [ucrs_pkg::PAIR_W-1:0]         pair_index,
  input  logic [ucrs_pkg::PIX_W-1:0]          chroma_blue,
  input  logic [ucrs_pkg::PIX_W-1:0]          luma_first,
  input  logic [ucrs_pkg::PIX_W-1:0]          chroma_red,
  input  logic [ucrs_pkg::PIX_W-1:0]          luma_second,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ucrs_pkg::MEAN_W-1:0]         mean_luma,
  output logic [ucrs_pkg::MEAN_W-1:0]         mean_blue_diff,
  output logic [ucrs_pkg::MEAN_W-1:0]         mean_red_diff,
  output logic [ucrs_pkg::TOTAL_W-1:0]        total_mean_luma,
  output logic [ucrs_pkg::TOTAL_W-1:0]        total_mean_blue,
  output logic [ucrs_pkg::TOTAL_W-1:0]        total_mean_red,
  output logic [ucrs_pkg::PIX_W-1:0]          lowest_luma,
  output logic [ucrs_pkg::PIX_W-1:0]          highest_luma,
  output logic [ucrs_pkg::CNT_W-1:0]          frames_counted,
  output logic [ucrs_pkg::CNT_W-1:0]          frames_without_source
);
  import ucrs_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Request sequencing.
  ucrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .action    (action_t'(action)),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Accumulators, divider and result register.
  ucrs_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk                   (clk),
    .rst                   (rst),
    .cfg_write             (cfg_write),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .line_index            (line_index),
    .pair_index            (pair_index),
    .chroma_blue           (chroma_blue),
    .luma_first            (luma_first),
    .chroma_red            (chroma_red),
    .luma_second           (luma_second),
    .cmd                   (cmd),
    .status                (status),
    .mean_luma             (mean_luma),
    .mean_blue_diff        (mean_blue_diff),
    .mean_red_diff         (mean_red_diff),
    .total_mean_luma       (total_mean_luma),
    .total_mean_blue       (total_mean_blue),
    .total_mean_red        (total_mean_red),
    .lowest_luma           (lowest_luma),
    .highest_luma          (highest_luma),
    .frames_counted        (frames_counted),
    .frames_without_source (frames_without_source)
  );

endmodule

// ===== sv/ucrs_checker.sv =====
// Port-level checks for the centre-region statistics unit, bound to the top.
// Depends on ucrs_pkg and the assertion macro header.
`include "uyvy_center_region_stats_unit_defines.svh"

module ucrs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [1:0]                    action,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ucrs_pkg::TOTAL_W-1:0]  total_mean_luma,
  input logic [ucrs_pkg::PIX_W-1:0]    lowest_luma,
  input logic [ucrs_pkg::PIX_W-1:0]    highest_luma,
  input logic [ucrs_pkg::CNT_W-1:0]    frames_counted
);
  import ucrs_pkg::*;

  // A stalled result stays put.
  `UCRS_ASSERT_NEXT(a_result_held, clk, rst, out_valid && out_stall, out_valid && $stable(total_mean_luma) && $stable(frames_counted), "stalled result changed")

  // Only an end-of-frame request can start the division sequence.
  `UCRS_ASSERT_NEXT(a_no_stall_after_other, clk, rst, in_valid && !in_stall && (action != ACT_END_FRAME), !in_stall, "stall after a request other than end of frame")

  // A new result follows a period of stalled input.
  `UCRS_ASSERT_IMPLY(a_result_after_stall, clk, rst, $rose(out_valid), $past(in_stall), "result appeared without the input being held")

  // Every result comes from a frame with samples.
  `UCRS_ASSERT_IMPLY(a_result_range, clk, rst, out_valid, (lowest_luma <= highest_luma) && (frames_counted != '0), "result shows an empty luma range")

endmodule

bind uyvy_center_region_stats_unit ucrs_checker u_checker (.*);
